### sv/lidar_occupancy_grid_marker_assert.svh
// assertion macros for the lidar occupancy grid marker
// expects signals named clk and rst in the scope of each use
`ifndef LIDAR_OCCUPANCY_GRID_MARKER_ASSERT_SVH
`define LIDAR_OCCUPANCY_GRID_MARKER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LOGM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define LOGM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LOGM_ASSERT_NOW(lbl, pre, post, msg)
`define LOGM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### sv/logm_pkg.sv
// shared constants, register codes and result item layout
// used by the grid marker top level and its multiplier
package logm_pkg;

  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 128;
  localparam int COL_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // sine polynomial coefficients, q14
  localparam logic [15:0] TRIG_QUARTER = 16'd16384;
  localparam logic [15:0] TRIG_C1 = 16'd1160;
  localparam logic [15:0] TRIG_C2 = 16'd10512;
  localparam logic [15:0] TRIG_C3 = 16'd25736;

  // divide by 16384000 = 2^17 * 125; floor(2^37 / 125) reciprocal
  localparam logic [MUL_W-1:0] DIV_CONST  = 32'd125;
  localparam logic [MUL_W-1:0] RECIP_125  = 32'd1099511627;

  localparam logic [15:0] RST_RANGE_LOW  = 16'd0;
  localparam logic [15:0] RST_RANGE_HIGH = 16'd65535;
  localparam logic [15:0] RST_ANGLE_START = 16'd0;
  localparam logic [15:0] RST_ANGLE_STEP = 16'd0;
  localparam logic [15:0] RST_HEADING    = 16'd0;
  localparam logic [23:0] RST_POSE_X     = 24'd12800;
  localparam logic [23:0] RST_POSE_Y     = 24'd12800;
  localparam logic [15:0] RST_CPM        = 16'd5120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW,
    REG_RANGE_HIGH,
    REG_ANGLE_START,
    REG_ANGLE_STEP,
    REG_HEADING,
    REG_POSE_X,
    REG_POSE_Y,
    REG_CPM
  } cfg_reg_t;

  // result item, lowest field last
  typedef struct packed {
    logic        occupied;
    logic [15:0] cell_y;
    logic [15:0] cell_x;
    logic        marked;
    logic        in_range;
  } logm_out_t;

endpackage

### sv/logm_ram.sv
// generic single-port ram with registered read data
// no package dependency
module logm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic                                     we,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/logm_mul.sv
// shared unsigned multiplier with registered product
// depends on logm_pkg for operand width
module logm_mul import logm_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
  end

endmodule

### sv/lidar_occupancy_grid_marker.sv
// lidar occupancy grid marker top level: sequencer, datapath, config registers
// depends on logm_pkg, logm_mul, logm_ram and the assertion macro header
//
//   channel | direction | handshake          | payload
//   s_*     | in        | s_tvalid/s_tready  | s_tdata, s_tuser (request kind)
//   m_*     | out       | m_tvalid/m_tready  | m_tdata (result item)
//   cfg_*   | in        | cfg_we             | cfg_index, cfg_data
//
// in-range sample: one item at a time (s_tready only in idle); 16 products
//   through the one shared 32x32 multiplier (angle, range scale, 2 x sine poly, 2 x divide)
// read request: one row read of the grid ram, then the done step
// rejected sample: no multiply, straight to the done step
// reset: grid ram is cleared one row per cycle, all GRID_HEIGHT rows, no items taken
// a finished result sits in the output register while the next item runs; the next
//   result waits in the done step until that one is taken
`include "lidar_occupancy_grid_marker_assert.svh"
module lidar_occupancy_grid_marker import logm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // beam_index[11:0], range_mm[27:12], read_x[34:28], read_y[41:35], zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // req_type[0]
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // in_range[0], marked[1], cell_x[17:2], cell_y[33:18], occupied[34], zero pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_ANG, ST_PROD, ST_Z, ST_Z2, ST_T1, ST_T2, ST_S,
    ST_Q1, ST_QE, ST_Q, ST_CELL, ST_LOOKUP, ST_MARK, ST_RDBIT, ST_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] range_low, range_high, angle_start, angle_step, heading, cpm;
  logic [23:0] pose_x, pose_y;

  // item and working registers
  logic               is_read;
  logic [11:0]        beam_idx;
  logic [15:0]        range_r;
  logic [15:0]        ang;        // beam angle
  logic [15:0]        trig_ang;   // angle fed to the sine pass
  logic               pass;       // 0 x (cosine), 1 y (sine)
  logic [MUL_W-1:0]   scale;      // range_mm * cells_per_meter
  logic [15:0]        z;
  logic [15:0]        z2;
  logic               neg;
  logic [30:0]        q1;
  logic [24:0]        qe;
  logic signed [25:0] dq;
  logic [15:0]        cx, cy;
  logic               hit;
  logic               in_range_r, marked_r, occupied_r;
  logm_out_t          out_r;
  logic [ROW_W-1:0]   clr_row;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  logm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // grid ram, one row of cells per word
  logic [ROW_W-1:0]      ram_addr;
  logic                  ram_we;
  logic [GRID_WIDTH-1:0] ram_wdata, ram_rdata, cell_mask;

  logm_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // input fields
  logic        in_req;
  logic [11:0] in_beam;
  logic [15:0] in_range_mm;
  logic [6:0]  in_rx, in_ry;

  assign in_req      = s_tuser[0];
  assign in_beam     = s_tdata[11:0];
  assign in_range_mm = s_tdata[27:12];
  assign in_rx       = s_tdata[34:28];
  assign in_ry       = s_tdata[41:35];

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(M_TDATA_W - $bits(logm_out_t)){1'b0}}, out_r};

  // sine argument folding: quadrant fraction in q14
  logic [15:0] z_calc;
  assign z_calc = trig_ang[14] ? (TRIG_QUARTER - {2'b00, trig_ang[13:0]})
                               : {2'b00, trig_ang[13:0]};

  // product slices; magnitudes bound each one
  logic [15:0] z2_calc, t1_calc, t2_calc, s_calc;
  logic [30:0] q1_calc;
  logic [24:0] qe_calc;
  assign z2_calc = prod[29:14];
  assign t1_calc = TRIG_C2 - {5'b0, prod[24:14]};
  assign t2_calc = TRIG_C3 - {2'b0, prod[27:14]};
  assign s_calc  = {1'b0, prod[28:14]};
  assign q1_calc = prod[47:17];
  assign qe_calc = prod[61:37];

  // one correction step after the reciprocal multiply
  logic [31:0] rem;
  logic [24:0] q_fix;
  assign rem   = {1'b0, q1} - prod[31:0];
  assign q_fix = qe + ((rem >= DIV_CONST) ? 25'd1 : 25'd0);

  // pose plus offset, divided by 256 toward zero, saturated
  logic signed [23:0] pose_sel;
  logic signed [26:0] sum, sum_adj, cdiv;
  logic [15:0]        cell_calc;
  assign pose_sel = pass ? signed'(pose_y) : signed'(pose_x);
  assign sum      = 27'(pose_sel) + 27'(dq);
  assign sum_adj  = sum[26] ? (sum + 27'sd255) : sum;
  assign cdiv     = sum_adj >>> 8;

  always_comb begin
    if (cdiv > 27'sd32767) begin
      cell_calc = 16'h7fff;
    end else if (cdiv < -27'sd32768) begin
      cell_calc = 16'h8000;
    end else begin
      cell_calc = cdiv[15:0];
    end
  end

  // cell inside the grid (read coordinates are zero-extended into cx/cy)
  logic in_grid;
  assign in_grid = !cx[15] && !cy[15] && (cx < 16'(GRID_WIDTH)) && (cy < 16'(GRID_HEIGHT));

  // multiplier operand selection per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_ANG: begin
        mul_a = 32'(beam_idx);
        mul_b = 32'(angle_step);
      end
      ST_PROD: begin
        mul_a = 32'(range_r);
        mul_b = 32'(cpm);
      end
      ST_Z: begin
        mul_a = 32'(z_calc);
        mul_b = 32'(z_calc);
      end
      ST_Z2: begin
        mul_a = 32'(TRIG_C1);
        mul_b = 32'(z2_calc);
      end
      ST_T1: begin
        mul_a = 32'(t1_calc);
        mul_b = 32'(z2);
      end
      ST_T2: begin
        mul_a = 32'(t2_calc);
        mul_b = 32'(z);
      end
      ST_S: begin
        mul_a = scale;
        mul_b = 32'(s_calc);
      end
      ST_Q1: begin
        mul_a = 32'(q1_calc);
        mul_b = RECIP_125;
      end
      ST_QE: begin
        mul_a = 32'(qe_calc);
        mul_b = DIV_CONST;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // grid ram port: clearing sweep, row reads, read-modify-write marking
  assign cell_mask = GRID_WIDTH'(1) << cx[COL_W-1:0];

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_addr  = clr_row;
      ram_we    = 1'b1;
      ram_wdata = '0;
    end else begin
      ram_addr  = cy[ROW_W-1:0];
      ram_we    = (state == ST_MARK) && hit;
      ram_wdata = ram_rdata | cell_mask;
    end
  end

  // configuration writes, taken at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low   <= RST_RANGE_LOW;
      range_high  <= RST_RANGE_HIGH;
      angle_start <= RST_ANGLE_START;
      angle_step  <= RST_ANGLE_STEP;
      heading     <= RST_HEADING;
      pose_x      <= RST_POSE_X;
      pose_y      <= RST_POSE_Y;
      cpm         <= RST_CPM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOW:   range_low   <= cfg_data[15:0];
        REG_RANGE_HIGH:  range_high  <= cfg_data[15:0];
        REG_ANGLE_START: angle_start <= cfg_data[15:0];
        REG_ANGLE_STEP:  angle_step  <= cfg_data[15:0];
        REG_HEADING:     heading     <= cfg_data[15:0];
        REG_POSE_X:      pose_x      <= cfg_data;
        REG_POSE_Y:      pose_y      <= cfg_data;
        REG_CPM:         cpm         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_row  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // the done step reloads the output register itself
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_row == ROW_W'(GRID_HEIGHT - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_row <= clr_row + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            is_read    <= in_req;
            beam_idx   <= in_beam;
            range_r    <= in_range_mm;
            marked_r   <= 1'b0;
            occupied_r <= 1'b0;
            pass       <= 1'b0;
            if (in_req) begin
              in_range_r <= 1'b0;
              cx         <= 16'(in_rx);
              cy         <= 16'(in_ry);
              state      <= ST_LOOKUP;
            end else if (in_range_mm > range_low && in_range_mm < range_high) begin
              in_range_r <= 1'b1;
              state      <= ST_ANG;
            end else begin
              in_range_r <= 1'b0;
              cx         <= '0;
              cy         <= '0;
              state      <= ST_DONE;
            end
          end
        end
        ST_ANG: begin
          state <= ST_PROD;
        end
        ST_PROD: begin
          // cosine first: angle plus a quarter turn
          ang      <= angle_start + prod[15:0] + heading;
          trig_ang <= angle_start + prod[15:0] + heading + TRIG_QUARTER;
          state    <= ST_Z;
        end
        ST_Z: begin
          if (!pass) begin
            scale <= prod[MUL_W-1:0];
          end
          z     <= z_calc;
          neg   <= trig_ang[15];
          state <= ST_Z2;
        end
        ST_Z2: begin
          z2    <= z2_calc;
          state <= ST_T1;
        end
        ST_T1: begin
          state <= ST_T2;
        end
        ST_T2: begin
          state <= ST_S;
        end
        ST_S: begin
          state <= ST_Q1;
        end
        ST_Q1: begin
          q1    <= q1_calc;
          state <= ST_QE;
        end
        ST_QE: begin
          qe    <= qe_calc;
          state <= ST_Q;
        end
        ST_Q: begin
          dq    <= neg ? -signed'({1'b0, q_fix}) : signed'({1'b0, q_fix});
          state <= ST_CELL;
        end
        ST_CELL: begin
          if (!pass) begin
            cx       <= cell_calc;
            pass     <= 1'b1;
            trig_ang <= ang;
            state    <= ST_Z;
          end else begin
            cy    <= cell_calc;
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          // row read issued this cycle, data next cycle
          hit   <= in_grid;
          state <= is_read ? ST_RDBIT : ST_MARK;
        end
        ST_MARK: begin
          marked_r <= hit;
          state    <= ST_DONE;
        end
        ST_RDBIT: begin
          occupied_r <= hit && ram_rdata[cx[COL_W-1:0]];
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_r.in_range <= in_range_r;
            out_r.marked   <= marked_r;
            out_r.cell_x   <= cx;
            out_r.cell_y   <= cy;
            out_r.occupied <= occupied_r;
            m_tvalid       <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // an accepted item keeps the input side closed for the next cycle
  `LOGM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")
  // a cell is only marked for a sample that passed the range limits
  `LOGM_ASSERT_NOW(a_mark_needs_range, m_tvalid && out_r.marked, out_r.in_range, "mark without range")
  // occupancy is reported only for read requests
  `LOGM_ASSERT_NOW(a_occ_only_reads, m_tvalid && out_r.occupied, !out_r.in_range && !out_r.marked, "occupied on sample")

endmodule
